// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types and constants for the max heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Command broadcast to every cell in the chain
	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic                  clr;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	// What one cell shows its neighbors
	typedef struct packed {
		logic                  place;
		logic                  valid;
		logic [VALUE_BITS-1:0] value;
	} link_t;

endpackage

// ===== hw/rtl/max_heap_priority_queue_top.sv =====
// Priority queue top: a descending chain of cells with a registered result word.
// The result word is registered when the input is accepted.
// Throughput: one item per cycle while in_ready is high; every cell compares and shifts in the same cycle.
// A result word waiting at the output does not stop the next item while out_ready is high.
// Reset (arst_n low) empties the queue and drops any pending result word.
module max_heap_priority_queue_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic [mhpq_pkg::VALUE_BITS-1:0]     value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [mhpq_pkg::VALUE_BITS-1:0]     top_value,
	output logic                                is_empty,
	output logic [mhpq_pkg::COUNT_BITS-1:0]     entry_count
);

	localparam int N = mhpq_pkg::CAPACITY;

	mhpq_pkg::cmd_t  cmd;
	mhpq_pkg::link_t links [N];
	mhpq_pkg::link_t lefts [N];
	mhpq_pkg::link_t rights[N];

	logic [mhpq_pkg::COUNT_BITS-1:0] count_q;
	logic [mhpq_pkg::COUNT_BITS-1:0] count_next;
	logic                            accept;
	logic                            full;
	logic                            empty;
	logic                            ok_next;
	logic [mhpq_pkg::VALUE_BITS-1:0] root_next;

	logic                            out_valid_q;
	logic                            ok_q;
	logic [mhpq_pkg::VALUE_BITS-1:0] top_q;
	logic [mhpq_pkg::COUNT_BITS-1:0] cnt_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == mhpq_pkg::COUNT_BITS'(N));
	assign empty    = (count_q == '0);

	// Decode the request into a chain command and the next count
	always_comb begin
		cmd.ins    = 1'b0;
		cmd.rem    = 1'b0;
		cmd.clr    = 1'b0;
		cmd.value  = value;
		ok_next    = 1'b0;
		count_next = count_q;
		unique case (op)
			mhpq_pkg::OP_INSERT: begin
				cmd.ins    = accept && !full;
				ok_next    = !full;
				count_next = full ? count_q : count_q + 1'b1;
			end
			mhpq_pkg::OP_REMOVE: begin
				cmd.rem    = accept && !empty;
				ok_next    = !empty;
				count_next = empty ? count_q : count_q - 1'b1;
			end
			mhpq_pkg::OP_CLEAR: begin
				cmd.clr    = accept;
				ok_next    = 1'b1;
				count_next = '0;
			end
			default: begin
				ok_next = 1'b0;
			end
		endcase
	end

	// Wire the chain; the head never takes a word from the left, the tail shifts in nothing
	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign lefts[i] = '{place: 1'b0, valid: 1'b0, value: '0};
			end else begin : g_mid_l
				assign lefts[i] = links[i-1];
			end
			if (i == N - 1) begin : g_tail
				assign rights[i] = '{place: 1'b0, valid: 1'b0, value: '0};
			end else begin : g_mid_r
				assign rights[i] = links[i+1];
			end
			mhpq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.left   (lefts[i]),
				.right  (rights[i]),
				.self   (links[i])
			);
		end
	endgenerate

	// Predict the head word after this request
	always_comb begin
		root_next = links[0].value;
		if (cmd.ins && links[0].place) begin
			root_next = value;
		end else if (cmd.rem) begin
			root_next = links[1].value;
		end
	end

	// Hold the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q  <= ok_next;
			cnt_q <= count_next;
			top_q <= (count_next == '0) ? '0 : root_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign top_value   = top_q;
	assign entry_count = cnt_q;
	assign is_empty    = (cnt_q == '0);

endmodule

// ===== hw/rtl/mhpq_cell.sv =====
// One slot of the sorted chain: holds a word and shifts toward either neighbor.
module mhpq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  mhpq_pkg::cmd_t cmd,
	input  mhpq_pkg::link_t left,
	input  mhpq_pkg::link_t right,
	output mhpq_pkg::link_t self
);

	logic                            valid_q;
	logic [mhpq_pkg::VALUE_BITS-1:0] value_q;
	logic                            place;

	// The new word lands here or lower when this slot is free or holds less
	assign place = !valid_q || (cmd.value > value_q);

	assign self.place = place;
	assign self.valid = valid_q;
	assign self.value = value_q;

	// Track occupancy; a slot fills at the insert point or when the left word shifts in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.rem) begin
			valid_q <= right.valid;
		end else if (cmd.ins) begin
			valid_q <= valid_q | (place & (!left.place | left.valid));
		end
	end

	// Shift the word right on insert, left on remove
	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			value_q <= right.value;
		end else if (cmd.ins && place) begin
			value_q <= left.place ? left.value : cmd.value;
		end
	end

endmodule
